[rtl/colormap_refcount_tracker_macros.svh]
// assertion macros for the colormap reference count tracker
`ifndef COLORMAP_REFCOUNT_TRACKER_MACROS_SVH
`define COLORMAP_REFCOUNT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define CMRT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CMRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CMRT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define CMRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/cmrt_pkg.sv]
// types and constants shared by the colormap reference count tracker
`default_nettype none
package cmrt_pkg;

    localparam int PIX_BITS = 8;
    localparam int ENTRIES  = 256;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_TRACKED   = 2'd0;
    localparam logic [1:0] ST_UNTRACKED = 2'd1;
    localparam logic [1:0] ST_NO_MAP    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [31:0] map_key;
        logic [23:0] pixel_value;
        logic        last_of_batch;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        release_color;
        logic [2:0]  map_slot;
        logic [15:0] count_after;
    } t_out_item;

    typedef struct packed {
        logic create;
        logic trk_off;
    } t_keytab_cmd;

    typedef struct packed {
        logic found;
        logic tracking;
        logic full;
    } t_look_flags;

endpackage
`default_nettype wire

[rtl/cmrt_keytab.sv]
// key table: slot keys, tracking enables and slot fill count with lookup
`default_nettype none
module cmrt_keytab import cmrt_pkg::*; #(
    parameter int MAX_MAPS = 8,
    parameter int SLOT_W   = 3,
    parameter int USED_W   = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [31:0]       i_key,
    input  wire t_keytab_cmd       i_cmd,
    output t_look_flags            o_flags,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [SLOT_W-1:0]      o_new_slot
);

    logic [31:0]       r_keys [MAX_MAPS];
    logic [MAX_MAPS-1:0] r_track;
    logic [USED_W-1:0] r_used;

    logic              lk_found;
    logic [SLOT_W-1:0] lk_slot;

    // lowest matching slot wins
    always_comb begin
        lk_found = 1'b0;
        lk_slot  = '0;
        for (int i = MAX_MAPS - 1; i >= 0; i--) begin
            if ((USED_W'(i) < r_used) && (r_keys[i] == i_key)) begin
                lk_found = 1'b1;
                lk_slot  = SLOT_W'(i);
            end
        end
    end

    assign o_slot         = lk_slot;
    assign o_new_slot     = r_used[SLOT_W-1:0];
    assign o_flags.found    = lk_found;
    assign o_flags.tracking = r_track[lk_slot];
    assign o_flags.full     = (r_used == USED_W'(MAX_MAPS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.create) begin
            r_keys[r_used[SLOT_W-1:0]] <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= '0;
            r_used  <= '0;
        end else begin
            if (i_cmd.create) begin
                r_track[r_used[SLOT_W-1:0]] <= 1'b1;
                r_used                      <= r_used + USED_W'(1);
            end
            if (i_cmd.trk_off) begin
                r_track[lk_slot] <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/cmrt_cntmem.sv]
// count memory: one write port, one read port with registered read data
`default_nettype none
module cmrt_cntmem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0]      o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/colormap_refcount_tracker.sv]
// a count update passes the lookup and modify states before the registered strobe
// early replies (no such map, table full, untracked) come from the lookup state
// slot creation adds a sweep clearing the new slot's 256 entries, then a second lookup
// no new item is taken until the result of the previous one is out
// busy drops as the strobe rises; results cannot be stalled
// synchronous active-low reset empties the key table; counts are cleared when a slot is made
`default_nettype none
`include "colormap_refcount_tracker_macros.svh"
module colormap_refcount_tracker import cmrt_pkg::*; #(
    parameter int MAX_MAPS   = 8,
    parameter int COUNT_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in_item i_item,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int SLOT_W = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
    localparam int USED_W = $clog2(MAX_MAPS + 1);
    localparam int ADDR_W = SLOT_W + PIX_BITS;
    localparam int DEPTH  = MAX_MAPS * ENTRIES;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;
    localparam logic [1:0] S_MOD   = 2'd3;

    logic [1:0]          r_state, n_state;
    t_in_item            r_item, n_item;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [PIX_BITS-1:0] r_clr, n_clr;
    logic                r_done, n_done;
    t_out_item           r_result, n_result;

    t_keytab_cmd         kt_cmd;
    t_look_flags         kt_flags;
    logic [SLOT_W-1:0]   kt_slot;
    logic [SLOT_W-1:0]   kt_new_slot;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;

    logic                pix_hi;
    logic [COUNT_BITS-1:0] cnt_new;
    logic                cnt_rel;

    cmrt_keytab #(
        .MAX_MAPS (MAX_MAPS),
        .SLOT_W   (SLOT_W),
        .USED_W   (USED_W)
    ) u_keytab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (r_item.map_key),
        .i_cmd      (kt_cmd),
        .o_flags    (kt_flags),
        .o_slot     (kt_slot),
        .o_new_slot (kt_new_slot)
    );

    cmrt_cntmem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_cntmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign pix_hi = |r_item.pixel_value[23:PIX_BITS];

    // saturating increment or clamped decrement of the read count
    always_comb begin
        cnt_new = mem_rdata;
        cnt_rel = 1'b0;
        if (r_item.mode == MODE_ALLOC) begin
            if (mem_rdata != {COUNT_BITS{1'b1}}) begin
                cnt_new = mem_rdata + COUNT_BITS'(1);
            end
        end else begin
            cnt_rel = (mem_rdata == COUNT_BITS'(1));
            if (mem_rdata != '0) begin
                cnt_new = mem_rdata - COUNT_BITS'(1);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_slot    = r_slot;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_result  = r_result;
        kt_cmd    = '0;
        mem_we    = 1'b0;
        mem_waddr = {r_slot, r_item.pixel_value[PIX_BITS-1:0]};
        mem_wdata = cnt_new;
        // read issued during lookup, data used in the modify state
        mem_raddr = {kt_slot, r_item.pixel_value[PIX_BITS-1:0]};
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!kt_flags.found) begin
                    if (r_item.mode == MODE_FREE) begin
                        n_done   = 1'b1;
                        n_result = '{ST_NO_MAP, 1'b0, 3'd0, 16'd0};
                        n_state  = S_IDLE;
                    end else if (kt_flags.full) begin
                        n_done   = 1'b1;
                        n_result = '{ST_FULL, 1'b0, 3'd0, 16'd0};
                        n_state  = S_IDLE;
                    end else begin
                        kt_cmd.create = 1'b1;
                        n_slot        = kt_new_slot;
                        n_clr         = '0;
                        n_state       = S_CLEAR;
                    end
                end else begin
                    n_slot = kt_slot;
                    if (!kt_flags.tracking || pix_hi) begin
                        kt_cmd.trk_off = kt_flags.tracking;
                        n_done   = 1'b1;
                        n_result = '{ST_UNTRACKED, 1'b0, 3'(kt_slot), 16'd0};
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_slot, r_clr};
                mem_wdata = '0;
                n_clr     = r_clr + PIX_BITS'(1);
                // sweep done: look up again, the new slot now matches
                if (r_clr == {PIX_BITS{1'b1}}) begin
                    n_state = S_LOOK;
                end
            end
            S_MOD: begin
                mem_we   = 1'b1;
                n_done   = 1'b1;
                n_result = '{ST_TRACKED, cnt_rel, 3'(r_slot), 16'(cnt_new)};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_slot   <= n_slot;
        r_clr    <= n_clr;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    `CMRT_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result while busy")
    `CMRT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "item not taken")
    `CMRT_ASSERT_SAME(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR, !n_done, "result in clear")
    `CMRT_ASSERT_SAME(a_release_zero, i_clk, i_rst_n, o_done && o_result.release_color, (o_result.status == ST_TRACKED) && (o_result.count_after == 16'd0), "bad release")

endmodule
`default_nettype wire

[bench/tb_top.sv]
// testbench for the colormap reference count tracker: directed table, random mix
`timescale 1ns / 1ps
module tb_top;
    import cmrt_pkg::*;

    localparam int MAX_MAPS   = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_ITEMS = 280;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    // shadow of the key table and the per-entry counts
    logic [31:0] map_keys [MAX_MAPS];
    int          maps_used = 0;
    bit          map_tracked [MAX_MAPS];
    logic [15:0] ref_cnt [MAX_MAPS][ENTRIES];

    t_out_item   pending_replies [$];
    t_row        dir_rows [$];
    logic [31:0] key_pool [9];
    int          n_errors = 0;
    int          idle_cycles = 0;

    colormap_refcount_tracker u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // applies one alloc or free to the shadow table and returns the reply
    function automatic t_out_item account_color(t_in_item it);
        t_out_item r;
        int        slot;
        bit        hit;
        logic [7:0] pix;
        r = '0;
        slot = 0;
        hit = 1'b0;
        for (int k = 0; k < maps_used; k++) begin
            if (!hit && map_keys[k] == it.map_key) begin
                slot = k;
                hit = 1'b1;
            end
        end
        if (!hit) begin
            if (it.mode == MODE_FREE) begin
                r.status = ST_NO_MAP;
                return r;
            end
            if (maps_used >= MAX_MAPS) begin
                r.status = ST_FULL;
                return r;
            end
            slot = maps_used;
            maps_used++;
            map_keys[slot] = it.map_key;
            map_tracked[slot] = 1'b1;
            for (int p = 0; p < ENTRIES; p++) ref_cnt[slot][p] = '0;
        end
        r.map_slot = 3'(slot);
        if (!map_tracked[slot]) begin
            r.status = ST_UNTRACKED;
            return r;
        end
        if (it.pixel_value >= ENTRIES) begin
            map_tracked[slot] = 1'b0;
            r.status = ST_UNTRACKED;
            return r;
        end
        pix = it.pixel_value[7:0];
        if (it.mode == MODE_ALLOC) begin
            if (ref_cnt[slot][pix] != '1) ref_cnt[slot][pix] = ref_cnt[slot][pix] + 16'd1;
        end else begin
            if (ref_cnt[slot][pix] == 16'd1) r.release_color = 1'b1;
            if (ref_cnt[slot][pix] != '0) ref_cnt[slot][pix] = ref_cnt[slot][pix] - 16'd1;
        end
        r.status = ST_TRACKED;
        r.count_after = ref_cnt[slot][pix];
        return r;
    endfunction

    task automatic add_row(logic mode, logic [31:0] key, logic [23:0] pix, logic last,
                           bit typed, logic [1:0] st, logic rel, logic [2:0] slot,
                           logic [15:0] cnt);
        t_row row;
        row.it = '{mode: mode, map_key: key, pixel_value: pix, last_of_batch: last};
        row.typed = typed;
        row.want = '{status: st, release_color: rel, map_slot: slot, count_after: cnt};
        dir_rows.push_back(row);
    endtask

    // holds start until the block takes the item, then optionally idles
    task automatic send_item(t_in_item it, bit typed, t_out_item want, int gap);
        t_out_item got;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        got = account_color(it);
        pending_replies.push_back(typed ? want : got);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                if (n_errors < 10)
                    $display("unexpected result: status %0d rel %0d slot %0d count %0d",
                             o_result.status, o_result.release_color, o_result.map_slot,
                             o_result.count_after);
                n_errors++;
            end else begin
                want = pending_replies.pop_front();
                if (o_result.status !== want.status ||
                    o_result.release_color !== want.release_color ||
                    o_result.map_slot !== want.map_slot ||
                    o_result.count_after !== want.count_after) begin
                    if (n_errors < 10)
                        $display({"mismatch: want st %0d rel %0d slot %0d cnt %0d, ",
                                  "got st %0d rel %0d slot %0d cnt %0d"},
                                 want.status, want.release_color, want.map_slot,
                                 want.count_after, o_result.status, o_result.release_color,
                                 o_result.map_slot, o_result.count_after);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("colormap_refcount_tracker regression: fail");
            $finish;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item none;
        int        idle_pct [4];
        int        gap;
        int        idx;
        int        kills_left;
        bit        on_tracked;

        none = '0;
        idle_pct = '{0, 64, 0, 8};
        kills_left = 2;
        key_pool = '{32'hA5A5_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5673,
                     32'h1234_5674, 32'h5A5A_C3C5, 32'h0F0F_7006, 32'h7FFF_FFF7,
                     32'h8000_0000};

        // slot creation order follows the pool, so pool index equals slot
        add_row(MODE_FREE,  key_pool[0], 24'd0,       1'b0, 1, ST_NO_MAP,    0, 0, 0);
        add_row(MODE_ALLOC, key_pool[0], 24'd0,       1'b0, 1, ST_TRACKED,   0, 0, 1);
        add_row(MODE_ALLOC, key_pool[0], 24'd255,     1'b0, 1, ST_TRACKED,   0, 0, 1);
        add_row(MODE_ALLOC, key_pool[0], 24'd0,       1'b1, 1, ST_TRACKED,   0, 0, 2);
        add_row(MODE_FREE,  key_pool[0], 24'd0,       1'b0, 1, ST_TRACKED,   0, 0, 1);
        add_row(MODE_FREE,  key_pool[0], 24'd0,       1'b1, 1, ST_TRACKED,   1, 0, 0);
        add_row(MODE_FREE,  key_pool[0], 24'd0,       1'b0, 1, ST_TRACKED,   0, 0, 0);
        add_row(MODE_ALLOC, key_pool[1], 24'hFFFFFF,  1'b1, 1, ST_UNTRACKED, 0, 1, 0);
        add_row(MODE_ALLOC, key_pool[1], 24'd3,       1'b0, 1, ST_UNTRACKED, 0, 1, 0);
        add_row(MODE_FREE,  key_pool[1], 24'd3,       1'b0, 1, ST_UNTRACKED, 0, 1, 0);
        add_row(MODE_ALLOC, key_pool[2], 24'd256,     1'b0, 1, ST_UNTRACKED, 0, 2, 0);
        add_row(MODE_ALLOC, key_pool[3], 24'd17,      1'b1, 1, ST_TRACKED,   0, 3, 1);
        add_row(MODE_FREE,  key_pool[3], 24'd17,      1'b1, 1, ST_TRACKED,   1, 3, 0);
        add_row(MODE_ALLOC, key_pool[4], 24'd128,     1'b0, 1, ST_TRACKED,   0, 4, 1);
        add_row(MODE_ALLOC, key_pool[5], 24'd1,       1'b0, 1, ST_TRACKED,   0, 5, 1);
        add_row(MODE_ALLOC, key_pool[6], 24'd2,       1'b1, 1, ST_TRACKED,   0, 6, 1);
        add_row(MODE_ALLOC, key_pool[7], 24'd254,     1'b0, 1, ST_TRACKED,   0, 7, 1);
        add_row(MODE_ALLOC, key_pool[8], 24'd0,       1'b0, 1, ST_FULL,      0, 0, 0);
        add_row(MODE_FREE,  key_pool[8], 24'hFFFFFF,  1'b1, 1, ST_NO_MAP,    0, 0, 0);
        add_row(MODE_FREE,  key_pool[7], 24'd254,     1'b0, 1, ST_TRACKED,   1, 7, 0);
        add_row(MODE_ALLOC, key_pool[6], 24'd2,       1'b0, 0, ST_TRACKED,   0, 0, 0);
        add_row(MODE_FREE,  key_pool[2], 24'hABCDEF,  1'b0, 0, ST_TRACKED,   0, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want, r % 3);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idx = $urandom_range(0, 99);
                if (idx < 85)
                    idx = $urandom_range(0, 7);
                else if (idx < 92)
                    idx = 8;
                else
                    idx = -1;
                it.map_key = (idx < 0) ? 32'($urandom) : key_pool[idx];
                it.mode = ($urandom_range(0, 1) == 0) ? MODE_ALLOC : MODE_FREE;
                it.last_of_batch = 1'($urandom_range(0, 1));
                on_tracked = (idx >= 0 && idx < MAX_MAPS) && map_tracked[idx];
                if ($urandom_range(0, 99) < 8) begin
                    it.pixel_value = 24'($urandom_range(256, 24'hFFFFFF));
                    // tracking off is permanent, so only a couple of live maps get killed
                    if (on_tracked) begin
                        if (kills_left > 0)
                            kills_left--;
                        else
                            it.pixel_value = {16'd0, it.pixel_value[7:0]};
                    end
                end else if ($urandom_range(0, 1) == 0) begin
                    it.pixel_value = 24'($urandom_range(0, 7));
                end else begin
                    it.pixel_value = 24'($urandom_range(0, 255));
                end
                gap = ($urandom_range(0, 99) < idle_pct[ph]) ? $urandom_range(1, 6) : 0;
                send_item(it, 0, none, gap);
            end
        end
        start <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && pending_replies.size() == 0)
            $display("colormap_refcount_tracker regression: pass");
        else
            $display("colormap_refcount_tracker regression: fail");
        $finish;
    end

endmodule
